[design/kvt_pkg.sv]
package kvt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int OUT_CNT_W = 7;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// Request token walking down the cell chain, collecting its answer.
	typedef struct packed {
		logic              valid;
		logic [1:0]        op;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		logic              hit;
		logic [DATA_W-1:0] old;
		logic              free_found;
		logic [IDX_W-1:0]  free_idx;
	} tok_t;

	// Insert of a new pair into one cell, broadcast from the chain tail.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} wr_t;

endpackage

[design/kvt_req_if.sv]
interface kvt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] key;
	logic signed [31:0] value;

	modport source (output valid, output req_type, output key, output value, input ready);
	modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

[design/kvt_rsp_if.sv]
interface kvt_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] old_value;
	logic               hit;
	logic               full_reject;
	logic [6:0]         entry_count;
	logic               is_empty;

	modport source (output valid, output old_value, output hit, output full_reject,
		output entry_count, output is_empty, input ready);
	modport sink (input valid, input old_value, input hit, input full_reject,
		input entry_count, input is_empty, output ready);
endinterface

[design/kvt_cell.sv]
module kvt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [kvt_pkg::IDX_W-1:0] cell_idx,
	input  kvt_pkg::tok_t             tok_in,
	input  kvt_pkg::wr_t              wr,
	output kvt_pkg::tok_t             tok_out
);

	logic                       ent_valid_q;
	logic [kvt_pkg::DATA_W-1:0] ent_key_q;
	logic [kvt_pkg::DATA_W-1:0] ent_value_q;
	logic                       tok_valid_q;
	kvt_pkg::tok_t              tok_q;
	kvt_pkg::tok_t              tok_d;
	logic                       match;
	logic                       ins;

	assign match = tok_in.valid && ent_valid_q && (ent_key_q == tok_in.key) &&
		(tok_in.op inside {kvt_pkg::OP_ADD, kvt_pkg::OP_SEARCH, kvt_pkg::OP_REMOVE});
	assign ins = wr.en && (wr.idx == cell_idx);

	always_comb begin
		tok_d = tok_in;
		if (match) begin
			tok_d.hit = 1'b1;
			tok_d.old = ent_value_q;
		end
		if (!tok_in.free_found && !ent_valid_q) begin
			tok_d.free_found = 1'b1;
			tok_d.free_idx   = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
			if (ins) begin
				ent_valid_q <= 1'b1;
			end else if (match && tok_in.op == kvt_pkg::OP_REMOVE) begin
				ent_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
		if (ins) begin
			ent_key_q   <= wr.key;
			ent_value_q <= wr.value;
		end else if (match && tok_in.op == kvt_pkg::OP_ADD) begin
			ent_value_q <= tok_in.value;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

[design/key_value_table_core.sv]
// The head cell registers the request token on the accepting edge; the token is then
// registered in each further cell in turn, then in the hold register, and the result is
// finally loaded into the output register, which raises result valid.
// Only one request is in the cell chain or hold register at a time; the token walks the cell chain.
// A new request is accepted while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous): all entries invalid, entry count zero, no result pending.
module key_value_table_core (
	input  logic   clk,
	input  logic   arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);

	localparam int N = kvt_pkg::CAPACITY;

	// Result record held between the chain tail and the output register.
	typedef struct packed {
		logic [kvt_pkg::DATA_W-1:0]    old;
		logic                          hit;
		logic                          full;
		logic [kvt_pkg::OUT_CNT_W-1:0] cnt;
		logic                          empty;
	} res_t;

	kvt_pkg::tok_t                chain_tok [N];
	kvt_pkg::tok_t                inj;
	kvt_pkg::tok_t                tail;
	kvt_pkg::wr_t                 wr;
	logic                         busy_q;
	logic                         pend_q;
	logic                         out_valid_q;
	logic [kvt_pkg::COUNT_W-1:0]  cnt_q;
	logic [kvt_pkg::COUNT_W-1:0]  cnt_d;
	res_t                         pend_res_q;
	res_t                         out_res_q;
	res_t                         res_d;
	logic                         accept;
	logic                         load_out;
	logic                         is_add;
	logic                         full_d;

	// Accept only when no request is in the chain or waiting in the hold register.
	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;

	// Inject a fresh token into the head cell on accept.
	always_comb begin
		inj            = '0;
		inj.valid      = accept;
		inj.op         = req.req_type;
		inj.key        = req.key;
		inj.value      = req.value;
	end

	// Row of cells: each holds one entry and passes the token to its neighbor.
	for (genvar i = 0; i < N; i++) begin : g_cell
		kvt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (kvt_pkg::IDX_W'(i)),
			.tok_in   ((i == 0) ? inj : chain_tok[(i == 0) ? 0 : i - 1]),
			.wr       (wr),
			.tok_out  (chain_tok[i])
		);
	end

	assign tail   = chain_tok[N-1];
	assign is_add = tail.op == kvt_pkg::OP_ADD;

	// At the tail: a new key claims the lowest free cell, or is rejected when none was seen.
	always_comb begin
		wr.en    = tail.valid && is_add && !tail.hit && tail.free_found;
		wr.idx   = tail.free_idx;
		wr.key   = tail.key;
		wr.value = tail.value;
		full_d   = is_add && !tail.hit && !tail.free_found;
	end

	always_comb begin
		cnt_d = cnt_q;
		if (wr.en) begin
			cnt_d = cnt_q + kvt_pkg::COUNT_W'(1);
		end else if (tail.valid && tail.hit && tail.op == kvt_pkg::OP_REMOVE) begin
			cnt_d = cnt_q - kvt_pkg::COUNT_W'(1);
		end
	end

	always_comb begin
		res_d.old   = tail.old;
		res_d.hit   = tail.hit;
		res_d.full  = full_d;
		res_d.cnt   = kvt_pkg::OUT_CNT_W'(cnt_d);
		res_d.empty = cnt_d == '0;
	end

	// Move the held result to the output register when it is empty or being drained.
	assign load_out = pend_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				pend_q <= 1'b1;
				cnt_q  <= cnt_d;
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			pend_res_q <= res_d;
		end
		if (load_out) begin
			out_res_q <= pend_res_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.old_value   = out_res_q.old;
	assign rsp.hit         = out_res_q.hit;
	assign rsp.full_reject = out_res_q.full;
	assign rsp.entry_count = out_res_q.cnt;
	assign rsp.is_empty    = out_res_q.empty;

endmodule
